@@ src/matrix_multiply_4x4_top_defines.svh @@
// Assertion macros used by the matrix multiply top level.
`ifndef MATRIX_MULTIPLY_4X4_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mm4_pkg.sv @@
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  localparam int MATRIX_DIM = 4;
  localparam int ELEM_W     = 32;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = PROD_W + $clog2(MATRIX_DIM);
  localparam int ROW_W      = $clog2(MATRIX_DIM);
  localparam int FRAC_W     = 5;
  localparam int DATA_BITS  = ROW_W + MATRIX_DIM * ELEM_W;
  localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - DATA_BITS;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);
  localparam logic [ADDR_W-1:0] ADDR_FRACTION_BITS = ADDR_W'(0);

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_MULTIPLY = 1'b1;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [MATRIX_DIM-1:0]   elem_vec_t;
  typedef elem_vec_t [MATRIX_DIM-1:0] mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [MATRIX_DIM-1:0]   prod_vec_t;
  typedef prod_vec_t [MATRIX_DIM-1:0] prod_mat_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef acc_t [MATRIX_DIM-1:0]    acc_vec_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [FRAC_W-1:0]        frac_t;

endpackage

@@ src/mm4_bstore.sv @@
// Right-matrix store: one row written per load beat, all entries cleared at reset.
module mm4_bstore (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  mm4_pkg::row_t     wr_row,
  input  mm4_pkg::elem_vec_t wr_data,
  output mm4_pkg::mat_t     b_mat
);
  import mm4_pkg::*;

  mat_t b_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_reg <= '0;
    end else if (wr_en) begin
      b_reg[wr_row] <= wr_data;
    end
  end

  assign b_mat = b_reg;

endmodule

@@ src/mm4_products.sv @@
// Product stage: sixteen 32x32 signed multiplies of the A row against B, registered.
module mm4_products (
  input  logic               clk,
  input  logic               en,
  input  mm4_pkg::elem_vec_t a_row,
  input  mm4_pkg::mat_t      b_mat,
  output mm4_pkg::prod_mat_t prod
);
  import mm4_pkg::*;

  prod_mat_t prod_reg;

  // prod_reg[k][j] = A[row][k] * B[k][j]
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MATRIX_DIM; k++) begin
        for (int j = 0; j < MATRIX_DIM; j++) begin
          prod_reg[k][j] <= PROD_W'($signed(a_row[k]) * $signed(b_mat[k][j]));
        end
      end
    end
  end

  assign prod = prod_reg;

endmodule

@@ src/mm4_col_sum.sv @@
// Column sum stage: add the four products of each column plus the rounding half.
module mm4_col_sum (
  input  logic               clk,
  input  logic               en,
  input  mm4_pkg::frac_t     frac,
  input  mm4_pkg::prod_mat_t prod,
  output mm4_pkg::acc_vec_t  sum
);
  import mm4_pkg::*;

  acc_t     half;
  acc_vec_t sum_next;
  acc_vec_t sum_reg;

  // Half an output LSB; zero when there are no fraction bits.
  assign half = (ACC_W'(1) << frac) >> 1;

  always_comb begin
    for (int j = 0; j < MATRIX_DIM; j++) begin
      sum_next[j] = half;
      for (int k = 0; k < MATRIX_DIM; k++) begin
        sum_next[j] = sum_next[j] + ACC_W'(prod[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_reg <= sum_next;
    end
  end

  assign sum = sum_reg;

endmodule

@@ src/mm4_round_sat.sv @@
// Output stage: drop fraction bits, clamp to 32 bits, register the product row.
module mm4_round_sat (
  input  logic               clk,
  input  logic               en,
  input  mm4_pkg::frac_t     frac,
  input  mm4_pkg::acc_vec_t  sum,
  input  mm4_pkg::row_t      row_in,
  output mm4_pkg::elem_vec_t prod,
  output mm4_pkg::row_t      row_out,
  output logic               saturated
);
  import mm4_pkg::*;

  acc_vec_t                  shifted;
  elem_vec_t                 prod_next;
  logic [MATRIX_DIM-1:0]     clamp;
  elem_vec_t                 prod_reg;
  row_t                      row_reg;
  logic                      sat_reg;

  always_comb begin
    for (int j = 0; j < MATRIX_DIM; j++) begin
      shifted[j] = sum[j] >>> frac;
      // In range only when every bit above the sign position matches it.
      if (!shifted[j][ACC_W-1] && (|shifted[j][ACC_W-2:ELEM_W-1])) begin
        prod_next[j] = ELEM_MAX;
        clamp[j]     = 1'b1;
      end else if (shifted[j][ACC_W-1] && !(&shifted[j][ACC_W-2:ELEM_W-1])) begin
        prod_next[j] = ELEM_MIN;
        clamp[j]     = 1'b1;
      end else begin
        prod_next[j] = shifted[j][ELEM_W-1:0];
        clamp[j]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_reg <= prod_next;
      row_reg  <= row_in;
      sat_reg  <= |clamp;
    end
  end

  assign prod      = prod_reg;
  assign row_out   = row_reg;
  assign saturated = sat_reg;

endmodule

@@ src/matrix_multiply_4x4_top.sv @@
// Top level of the streaming 4x4 fixed-point matrix multiplier.
//
// Input stream (s_axis): one beat per row. tuser = kind: a load beat writes
// row 'row' of the right matrix B and produces nothing; a multiply beat
// carries row 'row' of A and produces one output beat with that product row.
// Output stream (m_axis): out_row, four products, saturated flag in tuser.
// Elements are signed fixed point with fraction_bits fraction bits, set over
// the APB port at byte address 0 (reset value 16); write it only while idle.
// Each product is the exact four-term dot product, rounded to nearest (ties
// up) and clamped to 32 bits; saturated is high if any column clamped.
// A multiply beat passes the input, product, sum and output registers before
// it appears on m_axis. Throughput: one beat per cycle while the output is
// not stalled, load or multiply, in any mix; a load is visible to the very
// next multiply beat.
// Reset clears all stage valids, empties the output and sets B to all zeros.
// Output stall: each stage holds only while the stage after it is full and
// blocked, so bubbles collapse and input beats keep flowing until all four
// stages hold results; then s_axis_tready stays low while m_axis_tready does.
module matrix_multiply_4x4_top (
  input  logic                         clk,
  input  logic                         rst,
  // s_axis
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: row[1:0], elem0[33:2], elem1[65:34], elem2[97:66], elem3[129:98], zero pad
  input  logic [mm4_pkg::TDATA_W-1:0]  s_axis_tdata,
  // tuser: kind (0 load B row, 1 multiply A row)
  input  logic                         s_axis_tuser,
  // m_axis
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: out_row[1:0], prod0[33:2], prod1[65:34], prod2[97:66], prod3[129:98], zero pad
  output logic [mm4_pkg::TDATA_W-1:0]  m_axis_tdata,
  // tuser: saturated
  output logic                         m_axis_tuser,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mm4_pkg::ADDR_W-1:0]   paddr,
  input  logic [mm4_pkg::APB_W-1:0]    pwdata,
  output logic [mm4_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import mm4_pkg::*;
  `include "matrix_multiply_4x4_top_defines.svh"

  frac_t      fraction_bits;
  logic       in_beat;
  logic       load_beat;
  logic       mul_beat;
  row_t       in_row;
  elem_vec_t  in_elems;

  // stage valids and enables
  logic       v1, v2, v3, ov;
  logic       en1, en2, en3, en_o;
  row_t       row1, row2, row3;
  elem_vec_t  a1;

  mat_t       b_mat;
  prod_mat_t  prod_mat;
  acc_vec_t   col_sum;
  elem_vec_t  out_prod;
  row_t       out_row;
  logic       out_sat;
  logic       out_bound;

  // ---- configuration ----
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_bits <= FRAC_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_FRACTION_BITS) begin
      fraction_bits <= pwdata[FRAC_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_FRACTION_BITS) ? APB_W'(fraction_bits) : '0;

  // ---- input unpack ----
  assign in_row = s_axis_tdata[ROW_W-1:0];
  always_comb begin
    for (int k = 0; k < MATRIX_DIM; k++) begin
      in_elems[k] = s_axis_tdata[ROW_W + k*ELEM_W +: ELEM_W];
    end
  end

  // ---- flow control: a stage advances when the next one is empty or advancing ----
  assign en_o = !ov || m_axis_tready;
  assign en3  = !v3 || en_o;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;

  assign s_axis_tready = en1;
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign load_beat = in_beat && (s_axis_tuser == KIND_LOAD);
  assign mul_beat  = in_beat && (s_axis_tuser == KIND_MULTIPLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (en1)  v1 <= mul_beat;
      if (en2)  v2 <= v1;
      if (en3)  v3 <= v2;
      if (en_o) ov <= v3;
    end
  end

  // Input register: only multiply beats occupy the pipe.
  always_ff @(posedge clk) begin
    if (en1) begin
      row1 <= in_row;
      a1   <= in_elems;
    end
    if (en2) row2 <= row1;
    if (en3) row3 <= row2;
  end

  // ---- datapath ----
  // B is written at the load beat; any multiply ahead of it in the input
  // register takes its products at that same edge, from the old B.
  mm4_bstore u_bstore (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_beat),
    .wr_row  (in_row),
    .wr_data (in_elems),
    .b_mat   (b_mat)
  );

  mm4_products u_products (
    .clk   (clk),
    .en    (en2),
    .a_row (a1),
    .b_mat (b_mat),
    .prod  (prod_mat)
  );

  mm4_col_sum u_col_sum (
    .clk  (clk),
    .en   (en3),
    .frac (fraction_bits),
    .prod (prod_mat),
    .sum  (col_sum)
  );

  mm4_round_sat u_round_sat (
    .clk       (clk),
    .en        (en_o),
    .frac      (fraction_bits),
    .sum       (col_sum),
    .row_in    (row3),
    .prod      (out_prod),
    .row_out   (out_row),
    .saturated (out_sat)
  );

  // ---- output pack ----
  assign m_axis_tvalid = ov;
  assign m_axis_tuser  = out_sat;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[ROW_W-1:0] = out_row;
    for (int j = 0; j < MATRIX_DIM; j++) begin
      m_axis_tdata[ROW_W + j*ELEM_W +: ELEM_W] = out_prod[j];
    end
  end

  // Some column sits at a clamp bound.
  always_comb begin
    out_bound = 1'b0;
    for (int j = 0; j < MATRIX_DIM; j++) begin
      if (out_prod[j] == ELEM_MAX || out_prod[j] == ELEM_MIN) out_bound = 1'b1;
    end
  end

  // ---- assertions ----
  `MM4_ASSERT_NEXT(a_load_no_result, load_beat, !v1, "load beat entered the pipe")
  `MM4_ASSERT_NEXT(a_mul_enters, mul_beat, v1 && row1 == $past(in_row), "multiply not captured")
  `MM4_ASSERT_NEXT(a_stage3_holds, v3 && !en3, v3 && row3 == $past(row3), "sum stage lost row")
  `MM4_ASSERT_NOW(a_sat_clamped, ov && out_sat, out_bound, "saturated without a clamped column")

endmodule

@@ dv/matrix_multiply_4x4_top_tb.sv @@
// Self-checking testbench for the streaming 4x4 fixed-point matrix multiplier.
`timescale 1ns / 100ps

import mm4_pkg::*;

// Wide enough for four exact 64-bit products, the rounding bias and the shift.
typedef logic signed [71:0] dot_sum_t;

typedef struct packed {
  logic      saturated;
  elem_vec_t prod;
  row_t      row;
} product_row_t;

class matmul_scoreboard;
  elem_t          b_rows[MATRIX_DIM][MATRIX_DIM];
  frac_t          frac_bits;
  product_row_t   expected_rows[$];
  int             errors;

  function new();
    foreach (b_rows[r, c]) b_rows[r][c] = '0;
    frac_bits = FRAC_RESET;
    errors    = 0;
  endfunction

  function void set_fraction(frac_t f);
    frac_bits = f;
  endfunction

  function int pending();
    return expected_rows.size();
  endfunction

  // Apply one accepted input beat: store a B row, or predict one product row.
  function void note_row(logic kind, row_t row, elem_vec_t elems);
    product_row_t want;
    dot_sum_t     acc, a_term, b_term, hi_lim, lo_lim;
    int           j, k;
    hi_lim = ELEM_MAX;
    lo_lim = ELEM_MIN;
    if (kind == KIND_LOAD) begin
      for (k = 0; k < MATRIX_DIM; k++) b_rows[row][k] = $signed(elems[k]);
      return;
    end
    want.row       = row;
    want.saturated = 1'b0;
    for (j = 0; j < MATRIX_DIM; j++) begin
      acc = '0;
      for (k = 0; k < MATRIX_DIM; k++) begin
        a_term = $signed(elems[k]);
        b_term = b_rows[k][j];
        acc    = acc + a_term * b_term;
      end
      // round to nearest, ties toward plus infinity
      if (frac_bits != 0) acc = acc + (dot_sum_t'(1) <<< (frac_bits - 1));
      acc = acc >>> frac_bits;
      if (acc > hi_lim) begin
        want.prod[j]   = ELEM_MAX;
        want.saturated = 1'b1;
      end else if (acc < lo_lim) begin
        want.prod[j]   = ELEM_MIN;
        want.saturated = 1'b1;
      end else begin
        want.prod[j] = acc[ELEM_W-1:0];
      end
    end
    expected_rows.push_back(want);
  endfunction

  function void check_product(logic [TDATA_W-1:0] data, logic sat_flag);
    product_row_t want;
    elem_t        got;
    row_t         got_row;
    int           j;
    if (expected_rows.size() == 0) begin
      $error("product beat with no multiply pending: tdata=%h", data);
      errors++;
      return;
    end
    want    = expected_rows.pop_front();
    got_row = data[ROW_W-1:0];
    if (got_row !== want.row) begin
      $error("out_row: expected %0d, got %0d", want.row, got_row);
      errors++;
    end
    for (j = 0; j < MATRIX_DIM; j++) begin
      got = data[ROW_W + j*ELEM_W +: ELEM_W];
      if (got !== want.prod[j]) begin
        $error("prod%0d: expected %0d, got %0d", j, $signed(want.prod[j]), $signed(got));
        errors++;
      end
    end
    if (sat_flag !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, sat_flag);
      errors++;
    end
  endfunction
endclass

module matrix_multiply_4x4_top_tb;

  // Generous limit that stops a hung run.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 16;   // pipeline is four stages deep
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 128;

  localparam elem_t ONE  = 32'sd65536;   // 1.0 at the reset fraction width
  localparam elem_t HALF = 32'sd32768;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // tdata: row, elem0, elem1, elem2, elem3, zero pad (lowest bit first)
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  // tuser: kind
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // tdata: out_row, prod0, prod1, prod2, prod3, zero pad (lowest bit first)
  logic [TDATA_W-1:0] m_axis_tdata;
  // tuser: saturated
  logic               m_axis_tuser;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]   pwdata = '0;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  matmul_scoreboard sb;

  // Sender burst state and the hold-off request toggled by the stimulus.
  int   burst_left = 0;
  logic hold_off_flip = 1'b0;

  // Receiver pattern state, owned by the sink process; cycle_count is the watchdog's.
  logic hold_off_seen = 1'b0;
  int   hold_left = 0;
  int   pattern_left = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;

  matrix_multiply_4x4_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("matrix_multiply_4x4_top verification failed");
    $finish;
  end

  // Output side: check every accepted beat, then pick next cycle's tready.
  // The stall rate is redrawn when pattern_left runs out (zero rate gives clean
  // stretches); a flip of hold_off_flip starts a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_product(m_axis_tdata, m_axis_tuser);
      if (hold_off_flip != hold_off_seen) begin
        hold_off_seen = hold_off_flip;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (pattern_left == 0) begin
        pattern_left = 64;
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic elem_vec_t pack_row(elem_t e0, elem_t e1, elem_t e2, elem_t e3);
    return {e3, e2, e1, e0};
  endfunction

  // Mix extremes, small multiples of 1.0 and values of every magnitude.
  function automatic elem_t rand_elem(frac_t f);
    case ($urandom_range(9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return (elem_t'($urandom_range(16)) - elem_t'(8)) <<< f;
      4, 5:    return elem_t'($urandom);
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic elem_vec_t rand_row(frac_t f);
    return pack_row(rand_elem(f), rand_elem(f), rand_elem(f), rand_elem(f));
  endfunction

  // Offer one input beat and hold it until accepted. Open a new burst with a
  // random gap when the current one is used up.
  task automatic send_row(input logic kind, input row_t row, input elem_vec_t elems);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 3);
        default:    gap = $urandom_range(4, 12);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= TDATA_W'({elems, row});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_row(kind, row, elems);
  endtask

  // Drop valid, wait for every product row, then let trailing loads clear.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction(input frac_t f);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FRACTION_BITS;
    pwdata  <= APB_W'(f);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_fraction(f);
  endtask

  initial begin : stimulus
    int    p, r, sent;
    frac_t f;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset fraction width of 16.
    // B is cleared by reset: any A row gives zeros.
    send_row(KIND_MULTIPLY, 2'd0, pack_row(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN));
    // Identity B: rows pass through exactly, extremes included.
    for (r = 0; r < MATRIX_DIM; r++)
      send_row(KIND_LOAD, row_t'(r), pack_row(r == 0 ? ONE : '0, r == 1 ? ONE : '0,
                                              r == 2 ? ONE : '0, r == 3 ? ONE : '0));
    send_row(KIND_MULTIPLY, 2'd1, pack_row(ELEM_MIN, ELEM_MAX, '0, -32'sd1));
    send_row(KIND_MULTIPLY, 2'd2, pack_row(32'sd1, -32'sd1, 32'sd32767, -32'sd32768));
    // Half in B row 0: exact ties round up, the negative tie goes to zero.
    send_row(KIND_LOAD, 2'd0, pack_row(HALF, HALF, HALF, HALF));
    send_row(KIND_MULTIPLY, 2'd3, pack_row(32'sd1, '0, '0, '0));
    send_row(KIND_MULTIPLY, 2'd0, pack_row(-32'sd1, '0, '0, '0));
    send_row(KIND_MULTIPLY, 2'd1, pack_row(32'sd3, '0, '0, '0));
    // Full-scale B: saturate both ways, and a cancelling mix.
    for (r = 0; r < MATRIX_DIM; r++)
      send_row(KIND_LOAD, row_t'(r), pack_row(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
    send_row(KIND_MULTIPLY, 2'd0, pack_row(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
    send_row(KIND_MULTIPLY, 2'd1, pack_row(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
    send_row(KIND_MULTIPLY, 2'd2, pack_row(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN));
    send_row(KIND_LOAD, 2'd3, pack_row(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
    send_row(KIND_MULTIPLY, 2'd3, pack_row(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
    send_row(KIND_MULTIPLY, 2'd0, pack_row('0, '0, '0, '0));

    // Random phases, each at its own fraction width, extremes first.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       f = 5'd0;
        1:       f = 5'd31;
        2:       f = 5'd16;
        3:       f = 5'd1;
        4:       f = 5'd30;
        default: f = frac_t'($urandom_range(31));
      endcase
      settle();
      write_fraction(f);
      // Stall the output for a long stretch while beats keep coming.
      if (p == 2 || p == 5) hold_off_flip <= ~hold_off_flip;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(5) == 0) begin
          // whole matrix update, then the four A rows against it
          for (r = 0; r < MATRIX_DIM; r++) send_row(KIND_LOAD, row_t'(r), rand_row(f));
          for (r = 0; r < MATRIX_DIM; r++) send_row(KIND_MULTIPLY, row_t'(r), rand_row(f));
          sent += 2 * MATRIX_DIM;
        end else begin
          send_row(($urandom_range(99) < 35) ? KIND_LOAD : KIND_MULTIPLY,
                   row_t'($urandom_range(3)), rand_row(f));
          sent++;
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("matrix_multiply_4x4_top verification clean");
    end else begin
      $display("matrix_multiply_4x4_top verification failed");
    end
    $finish;
  end

endmodule

@@ matrix_multiply_4x4_top.f @@
+incdir+src
src/mm4_pkg.sv
src/mm4_bstore.sv
src/mm4_products.sv
src/mm4_col_sum.sv
src/mm4_round_sat.sv
src/matrix_multiply_4x4_top.sv
dv/matrix_multiply_4x4_top_tb.sv
